// File: rtl/wmfs_pkg.sv
// shared constants and register codes for the window minimum filter
`timescale 1ns / 1ps

package wmfs_pkg;

	// default sizes of the design
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_WIN_W  = 16;
	localparam int MAX_WIN_H  = 16;
	localparam int PIXEL_BITS = 30;

	// fixed field and register widths
	localparam int SUM_W      = 63;
	localparam int IMG_W_BITS = 11;
	localparam int IMG_H_BITS = 16;
	localparam int WIN_BITS   = 5;
	localparam int ROW_W      = 16;

	// configuration port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// register reset values
	localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = IMG_W_BITS'(1024);
	localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = IMG_H_BITS'(1024);
	localparam logic [WIN_BITS-1:0]   WIN_W_RESET = WIN_BITS'(1);
	localparam logic [WIN_BITS-1:0]   WIN_H_RESET = WIN_BITS'(1);

	// register index codes, taken from paddr[3:2]
	localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd2;
	localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd3;

endpackage

// File: rtl/wmfs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module wmfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/wmfs_min_tree.sv
// balanced minimum tree over enabled leaves, disabled leaves count as all ones
`timescale 1ns / 1ps

module wmfs_min_tree #(
	parameter int N     = 2,
	parameter int WIDTH = 8
) (
	input  logic [WIDTH-1:0] leaf [N],
	input  logic [N-1:0]     en,
	output logic [WIDTH-1:0] min_out
);

	localparam int P = 1 << $clog2(N);

	logic [WIDTH-1:0] padded [P];
	logic [WIDTH-1:0] node [1:2*P-1];

	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < N) begin : g_real
			assign padded[i] = en[i] ? leaf[i] : '1;
		end else begin : g_pad
			assign padded[i] = '1;
		end
	end

	always_comb begin
		for (int i = 0; i < P; i++) begin
			node[P+i] = padded[i];
		end
		for (int i = P - 1; i >= 1; i--) begin
			node[i] = (node[2*i] < node[2*i+1]) ? node[2*i] : node[2*i+1];
		end
	end

	assign min_out = node[1];

endmodule

// File: rtl/window_min_filter_sum.sv
// top level: two-dimensional sliding window minimum with running sum
`timescale 1ns / 1ps

// usage
//  - pixels arrive in raster order on the s_ stream, one pixel per transfer
//  - every pixel gives exactly one result transfer on the m_ stream: the window
//    minimum (zero when no full window ends here), the running saturating sum,
//    a tuser flag for a full window and tlast on the last pixel of the image
//  - the user sets image and window sizes on the apb port while the block is idle; not enforced
//  - throughput is one pixel per cycle while m_tready holds: the row minimum
//    tree and the line buffer write sit in front of the first stage, one ram
//    per window row line is read at the pixel's column in the same cycle
//  - from the accepting edge to m_tvalid a pixel passes row minimum and ram
//    read, column minimum tree, saturating add into the output register
//  - reset clears counters, sum, row shift line, valid and config registers;
//    line buffers need no clearing pass, a full window reads only written entries
//  - a stalled receiver holds the output register; the pipeline keeps taking
//    pixels until all three stages are full, then s_tready drops
module window_min_filter_sum #(
	parameter int MAX_WIDTH  = wmfs_pkg::MAX_WIDTH,
	parameter int MAX_WIN_W  = wmfs_pkg::MAX_WIN_W,
	parameter int MAX_WIN_H  = wmfs_pkg::MAX_WIN_H,
	parameter int PIXEL_BITS = wmfs_pkg::PIXEL_BITS,
	localparam int IN_DW  = ((PIXEL_BITS + 7) / 8) * 8,
	localparam int OUT_DW = ((PIXEL_BITS + wmfs_pkg::SUM_W + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wmfs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [wmfs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [wmfs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	// pixel stream in
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [IN_DW-1:0]                  s_tdata,  // pixel
	// result stream out
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [OUT_DW-1:0]                 m_tdata,  // window_min, sum_so_far
	output logic                              m_tlast,  // frame_done
	output logic                              m_tuser   // window_valid
);

	localparam int SUM_W = wmfs_pkg::SUM_W;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WLW   = CW + 1;
	localparam int WWB   = $clog2(MAX_WIN_W + 1);
	localparam int WHB   = $clog2(MAX_WIN_H + 1);
	localparam int LB    = $clog2(MAX_WIN_H);
	localparam int ROW_W = wmfs_pkg::ROW_W;
	localparam int RWN   = MAX_WIN_W - 1;

	typedef struct packed {
		logic                  win_ok;
		logic                  last;
		logic [LB-1:0]         line;
		logic [PIXEL_BITS-1:0] rmin;
	} s1_t;

	typedef struct packed {
		logic                  win_ok;
		logic                  last;
		logic [PIXEL_BITS-1:0] wmin;
	} s2_t;

	// configuration registers, raw as written
	logic [wmfs_pkg::IMG_W_BITS-1:0] img_w_q;
	logic [wmfs_pkg::IMG_H_BITS-1:0] img_h_q;
	logic [wmfs_pkg::WIN_BITS-1:0]   win_w_q;
	logic [wmfs_pkg::WIN_BITS-1:0]   win_h_q;

	logic       cfg_wr;
	logic [1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= wmfs_pkg::IMG_W_RESET;
			img_h_q <= wmfs_pkg::IMG_H_RESET;
			win_w_q <= wmfs_pkg::WIN_W_RESET;
			win_h_q <= wmfs_pkg::WIN_H_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				wmfs_pkg::REG_IMAGE_WIDTH:   img_w_q <= pwdata[wmfs_pkg::IMG_W_BITS-1:0];
				wmfs_pkg::REG_IMAGE_HEIGHT:  img_h_q <= pwdata[wmfs_pkg::IMG_H_BITS-1:0];
				wmfs_pkg::REG_WINDOW_WIDTH:  win_w_q <= pwdata[wmfs_pkg::WIN_BITS-1:0];
				wmfs_pkg::REG_WINDOW_HEIGHT: win_h_q <= pwdata[wmfs_pkg::WIN_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			wmfs_pkg::REG_IMAGE_WIDTH:   prdata = wmfs_pkg::APB_DATA_W'(img_w_q);
			wmfs_pkg::REG_IMAGE_HEIGHT:  prdata = wmfs_pkg::APB_DATA_W'(img_h_q);
			wmfs_pkg::REG_WINDOW_WIDTH:  prdata = wmfs_pkg::APB_DATA_W'(win_w_q);
			wmfs_pkg::REG_WINDOW_HEIGHT: prdata = wmfs_pkg::APB_DATA_W'(win_h_q);
		endcase
	end

	// effective sizes: zero acts as one; image width and window sizes clamp to the maximum, image height does not
	logic [WLW-1:0]                  w_lim;
	logic [wmfs_pkg::IMG_H_BITS-1:0] h_lim;
	logic [WWB-1:0]                  ww_lim;
	logic [WHB-1:0]                  wh_lim;

	always_comb begin
		if (img_w_q == '0) begin
			w_lim = WLW'(1);
		end else if (32'(img_w_q) > 32'(MAX_WIDTH)) begin
			w_lim = WLW'(MAX_WIDTH);
		end else begin
			w_lim = WLW'(img_w_q);
		end

		h_lim = (img_h_q == '0) ? wmfs_pkg::IMG_H_BITS'(1) : img_h_q;

		if (win_w_q == '0) begin
			ww_lim = WWB'(1);
		end else if (32'(win_w_q) > 32'(MAX_WIN_W)) begin
			ww_lim = WWB'(MAX_WIN_W);
		end else begin
			ww_lim = WWB'(win_w_q);
		end

		if (win_h_q == '0) begin
			wh_lim = WHB'(1);
		end else if (32'(win_h_q) > 32'(MAX_WIN_H)) begin
			wh_lim = WHB'(MAX_WIN_H);
		end else begin
			wh_lim = WHB'(win_h_q);
		end
	end

	// pipeline handshake
	logic s1_v_q, s2_v_q, out_v_q;
	logic out_rdy, s2_rdy, acc;

	assign out_rdy  = !out_v_q || m_tready;
	assign s2_rdy   = !s2_v_q || out_rdy;
	assign s_tready = !s1_v_q || s2_rdy;
	assign acc      = s_tvalid && s_tready;

	// raster position of the next pixel; line_q follows row_q modulo the line count
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [LB-1:0]    line_q;

	logic [PIXEL_BITS-1:0] px;
	logic                  row_end, frame_end, row_ok, win_ok;

	assign px        = s_tdata[PIXEL_BITS-1:0];
	assign row_end   = (WLW'(col_q) + WLW'(1)) >= w_lim;
	assign frame_end = row_end && ((17'(row_q) + 17'd1) >= 17'(h_lim));
	assign row_ok    = (32'(col_q) + 32'd1) >= 32'(ww_lim);
	assign win_ok    = row_ok && ((32'(row_q) + 32'd1) >= 32'(wh_lim));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			line_q <= '0;
		end else if (acc) begin
			if (frame_end) begin
				col_q  <= '0;
				row_q  <= '0;
				line_q <= '0;
			end else if (row_end) begin
				col_q  <= '0;
				row_q  <= row_q + ROW_W'(1);
				line_q <= (32'(line_q) == MAX_WIN_H - 1) ? '0 : line_q + LB'(1);
			end else begin
				col_q  <= col_q + CW'(1);
			end
		end
	end

	// newest pixels of the row, [0] newest
	logic [PIXEL_BITS-1:0] rw_q [RWN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RWN; i++) begin
				rw_q[i] <= '0;
			end
		end else if (acc) begin
			rw_q[0] <= px;
			for (int i = 1; i < RWN; i++) begin
				rw_q[i] <= rw_q[i-1];
			end
		end
	end

	// row minimum over the newest window_width pixels including this one
	logic [PIXEL_BITS-1:0] row_leaf [MAX_WIN_W];
	logic [MAX_WIN_W-1:0]  row_en;
	logic [PIXEL_BITS-1:0] rmin;

	always_comb begin
		row_leaf[0] = px;
		row_en[0]   = 1'b1;
		for (int i = 1; i < MAX_WIN_W; i++) begin
			row_leaf[i] = rw_q[i-1];
			row_en[i]   = 32'(i) < 32'(ww_lim);
		end
	end

	wmfs_min_tree #(
		.N     (MAX_WIN_W),
		.WIDTH (PIXEL_BITS)
	) u_row_tree (
		.leaf    (row_leaf),
		.en      (row_en),
		.min_out (rmin)
	);

	// line buffers: one ram per line, written at the accepting edge, all read
	// at the pixel's column so that the data lines up with stage one
	logic [PIXEL_BITS-1:0] line_rd [MAX_WIN_H];

	for (genvar j = 0; j < MAX_WIN_H; j++) begin : g_line
		wmfs_ram #(
			.WIDTH (PIXEL_BITS),
			.DEPTH (MAX_WIDTH)
		) u_line_ram (
			.clk   (clk),
			.we    (acc && row_ok && (line_q == LB'(j))),
			.waddr (col_q),
			.wdata (rmin),
			.re    (acc),
			.raddr (col_q),
			.rdata (line_rd[j])
		);
	end

	// stage one
	s1_t s1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s_tready) begin
			s1_v_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_s1.win_ok <= win_ok;
			s1_s1.last   <= frame_end;
			s1_s1.line   <= line_q;
			s1_s1.rmin   <= rmin;
		end
	end

	// column minimum: own row minimum plus the window_height-1 lines above
	logic [PIXEL_BITS-1:0] col_leaf [MAX_WIN_H+1];
	logic [MAX_WIN_H:0]    col_en;
	logic [PIXEL_BITS-1:0] wmin;

	always_comb begin
		int lines_back;
		col_leaf[0] = s1_s1.rmin;
		col_en[0]   = 1'b1;
		for (int j = 0; j < MAX_WIN_H; j++) begin
			// rows back from the current line, modulo the line count
			if (32'(s1_s1.line) >= j) begin
				lines_back = 32'(s1_s1.line) - j;
			end else begin
				lines_back = 32'(s1_s1.line) + MAX_WIN_H - j;
			end
			col_leaf[j+1] = line_rd[j];
			col_en[j+1]   = (lines_back >= 1) && (lines_back < 32'(wh_lim));
		end
	end

	wmfs_min_tree #(
		.N     (MAX_WIN_H + 1),
		.WIDTH (PIXEL_BITS)
	) u_col_tree (
		.leaf    (col_leaf),
		.en      (col_en),
		.min_out (wmin)
	);

	// stage two
	s2_t s2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (s2_rdy) begin
			s2_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v_q && s2_rdy) begin
			s2_s2.win_ok <= s1_s1.win_ok;
			s2_s2.last   <= s1_s1.last;
			s2_s2.wmin   <= s1_s1.win_ok ? wmin : '0;
		end
	end

	// running sum, saturating at all ones; cleared after the frame's last pixel
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_next;
	logic             s2_adv;

	assign s2_adv  = s2_v_q && out_rdy;
	assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(s2_s2.wmin);

	always_comb begin
		if (!s2_s2.win_ok) begin
			sum_next = sum_q;
		end else if (sum_add[SUM_W]) begin
			sum_next = '1;
		end else begin
			sum_next = sum_add[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (s2_adv) begin
			sum_q <= s2_s2.last ? '0 : sum_next;
		end
	end

	// output register
	logic [PIXEL_BITS-1:0] out_min_q;
	logic [SUM_W-1:0]      out_sum_q;
	logic                  out_last_q;
	logic                  out_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_rdy) begin
			out_v_q <= s2_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_min_q  <= s2_s2.wmin;
			out_sum_q  <= sum_next;
			out_last_q <= s2_s2.last;
			out_flag_q <= s2_s2.win_ok;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_DW'({out_sum_q, out_min_q});
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_flag_q;

endmodule
